>>> hdl/lkvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } stat_t;

endpackage

`default_nettype wire

>>> hdl/lru_key_value_cache.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | handshake           | payload
// --------+-----+---------------------+-------------------------
// in      | in  | in_valid / in_stall | mode, key, data_in
// out     | out | out_valid/out_stall | found, data_out, evicted
// cfg     | in  | cfg_wr_en           | cfg_wr_data (capacity)
//
// One word in flight: a word passes through the scan, update and done states,
// and the next word is accepted only after its result word is taken.
// The key store is scanned one entry a cycle through its single read port.
// in_stall stays high from acceptance until the result word is taken.
// rst is synchronous; it empties the cache and sets capacity to 16.

module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic signed [lkvc_pkg::KEY_W-1:0]  key,
  input  logic signed [lkvc_pkg::DATA_W-1:0] data_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               found,
  output logic signed [lkvc_pkg::DATA_W-1:0] data_out,
  output logic                               evicted,
  input  logic                               cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0]         cfg_wr_data
);
  import lkvc_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [8:0] ENT_W9 = 9'(ENTRIES);

  logic [CAP_W-1:0] capacity;
  logic [8:0]       cap_wide;
  logic [CNT_W-1:0] eff_cap;
  cmd_t             cmd;
  stat_t            status;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // zero acts as one, anything above the entry count as the entry count
  always_comb begin
    cap_wide = {4'd0, capacity};
    if (cap_wide == 9'd0) begin
      cap_wide = 9'd1;
    end else if (cap_wide > ENT_W9) begin
      cap_wide = ENT_W9;
    end
  end

  assign eff_cap = cap_wide[CNT_W-1:0];

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  lkvc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .eff_cap  (eff_cap),
    .mode     (mode),
    .key      (key),
    .data_in  (data_in),
    .found    (found),
    .data_out (data_out),
    .evicted  (evicted)
  );

endmodule

`default_nettype wire

>>> hdl/lkvc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output lkvc_pkg::cmd_t  cmd,
  input  lkvc_pkg::stat_t status
);
  import lkvc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_UPDATE = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lkvc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lkvc_dp #(
  parameter int ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lkvc_pkg::cmd_t                    cmd,
  output lkvc_pkg::stat_t                   status,
  input  logic [$clog2(ENTRIES + 1)-1:0]    eff_cap,
  input  logic                              mode,
  input  logic signed [lkvc_pkg::KEY_W-1:0]  key,
  input  logic signed [lkvc_pkg::DATA_W-1:0] data_in,
  output logic                              found,
  output logic signed [lkvc_pkg::DATA_W-1:0] data_out,
  output logic                              evicted
);
  import lkvc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_N = CNT_W'(ENTRIES);

  logic [KEY_W-1:0]  key_mem [ENTRIES];
  logic [DATA_W-1:0] val_mem [ENTRIES];

  logic [ENTRIES-1:0] valid, valid_next;
  logic [IDX_W-1:0]   rank      [ENTRIES];
  logic [IDX_W-1:0]   rank_next [ENTRIES];
  logic [CNT_W-1:0]   live, live_next;
  logic [CNT_W-1:0]   live_m1_w, live_m2_w;
  logic [IDX_W-1:0]   live_m1, live_m2;

  logic              req_mode;
  logic [KEY_W-1:0]  req_key;
  logic [DATA_W-1:0] req_data;

  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] scan_addr;
  logic             rd_vld;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx, rd_rank;
  logic [KEY_W-1:0] rd_key;

  logic             hit_f, free_f;
  logic [IDX_W-1:0] hit_idx, hit_rank, free_idx, vic_idx, vic2_idx;

  logic             is_put, put_miss, ev_hit, ev_miss, do_ev;
  logic [IDX_W-1:0] ev_idx, ins_idx, put_idx;

  logic [DATA_W-1:0] val_rd;
  logic              found_r, evicted_r, get_hit;

  assign scan_addr        = cnt[IDX_W-1:0];
  assign status.scan_done = (cnt == CNT_N);

  assign live_m1_w = live - CNT_W'(1);
  assign live_m2_w = live - CNT_W'(2);
  assign live_m1   = live_m1_w[IDX_W-1:0];
  assign live_m2   = live_m2_w[IDX_W-1:0];

  assign is_put   = (req_mode == MODE_PUT);
  assign put_miss = is_put && !hit_f;
  assign ev_hit   = is_put && hit_f && (live > eff_cap);
  assign ev_miss  = put_miss && (live >= eff_cap);
  assign do_ev    = ev_hit || ev_miss;
  // a refreshed victim hands the oldest place to the next oldest
  assign ev_idx   = (hit_f && (hit_rank == live_m1)) ? vic2_idx : vic_idx;
  assign ins_idx  = (ev_miss && (!free_f || (vic_idx < free_idx))) ? vic_idx : free_idx;
  assign put_idx  = hit_f ? hit_idx : ins_idx;

  always_comb begin
    live_next = live;
    if (put_miss) begin
      live_next = live_next + CNT_W'(1);
    end
    if (do_ev) begin
      live_next = live_next - CNT_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_next[i] = valid[i];
      rank_next[i]  = rank[i];
      if (hit_f) begin
        if (IDX_W'(i) == hit_idx) begin
          rank_next[i] = '0;
        end else if (valid[i] && (rank[i] < hit_rank)) begin
          rank_next[i] = rank[i] + IDX_W'(1);
        end
      end else if (put_miss && valid[i]) begin
        rank_next[i] = rank[i] + IDX_W'(1);
      end
      if (do_ev && (IDX_W'(i) == ev_idx)) begin
        valid_next[i] = 1'b0;
        rank_next[i]  = '0;
      end
      if (put_miss && (IDX_W'(i) == ins_idx)) begin
        valid_next[i] = 1'b1;
        rank_next[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rd_vld <= 1'b0;
      live   <= '0;
      valid  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        cnt    <= '0;
        rd_vld <= 1'b0;
      end else if (cmd.scan) begin
        if (cnt < CNT_N) begin
          cnt <= cnt + CNT_W'(1);
        end
        rd_vld <= (cnt < CNT_N);
      end
      if (cmd.update) begin
        live  <= live_next;
        valid <= valid_next;
        for (int i = 0; i < ENTRIES; i++) begin
          rank[i] <= rank_next[i];
        end
      end
    end
  end

  // key store: one read a cycle during the scan, written on insert
  always_ff @(posedge clk) begin
    if (cmd.scan && (cnt < CNT_N)) begin
      rd_key   <= key_mem[scan_addr];
      rd_rank  <= rank[scan_addr];
      rd_valid <= valid[scan_addr];
      rd_idx   <= scan_addr;
    end
    if (cmd.update && put_miss) begin
      key_mem[ins_idx] <= req_key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (is_put) begin
        val_mem[put_idx] <= req_data;
      end
      val_rd <= val_mem[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= mode;
      req_key  <= key;
      req_data <= data_in;
      hit_f    <= 1'b0;
      free_f   <= 1'b0;
    end else if (cmd.scan && rd_vld) begin
      if (rd_valid && (rd_key == req_key)) begin
        hit_f    <= 1'b1;
        hit_idx  <= rd_idx;
        hit_rank <= rd_rank;
      end
      if (!rd_valid && !free_f) begin
        free_f   <= 1'b1;
        free_idx <= rd_idx;
      end
      if (rd_valid && (live != '0) && (rd_rank == live_m1)) begin
        vic_idx <= rd_idx;
      end
      if (rd_valid && (live >= CNT_W'(2)) && (rd_rank == live_m2)) begin
        vic2_idx <= rd_idx;
      end
    end
    if (cmd.update) begin
      found_r   <= hit_f;
      evicted_r <= do_ev;
      get_hit   <= !is_put && hit_f;
    end
  end

  assign found    = found_r;
  assign evicted  = evicted_r;
  assign data_out = get_hit ? val_rd : '0;

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CNT_N)
    else $error("live count above entry count");

  a_live_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(live))
    else $error("live count disagrees with valid marks");

  a_get_no_evict: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && !is_put) |=> !evicted_r)
    else $error("get reported an eviction");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && put_miss && !do_ev) |=> (live == $past(live) + CNT_W'(1)))
    else $error("insert without eviction did not grow live count");
`endif

endmodule

`default_nettype wire
